// ----- sv/div64_pkg.sv -----
// Shared types and constants for the 64-bit signed/unsigned divider.
package div64_pkg;

   // Width of the data fields on the request and response ports.
   localparam int PORT_WIDTH = 64;

   // Division mode carried by each request.
   localparam logic CMD_UNSIGNED = 1'b0;
   localparam logic CMD_SIGNED   = 1'b1;

   // Status of the shift-subtract unit as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div64_status_type;

endpackage

// ----- sv/div64_cneg.sv -----
// Conditional two's complement negator shared by the sign fix-up steps.
module div64_cneg #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                  enable,
   input  logic [DATA_WIDTH-1:0] value,
   output logic [DATA_WIDTH-1:0] result
);

   // Negate when enabled, otherwise pass the value unchanged.
   assign result = enable ? (~value + DATA_WIDTH'(1)) : value;

endmodule

// ----- sv/div64_core.sv -----
// Restoring shift-subtract division unit, one quotient bit per cycle.
module div64_core #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DATA_WIDTH-1:0]        dividend,
   input  logic [DATA_WIDTH-1:0]        divisor,
   output div64_pkg::div64_status_type  status,
   output logic [DATA_WIDTH-1:0]        quotient,
   output logic [DATA_WIDTH-1:0]        remainder
);
   import div64_pkg::*;

   localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] div_ff, div_in;

   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH+1:0] diff;
   logic                  borrow;
   logic                  last;

   // Trial subtraction of the divisor from the shifted partial remainder.
   assign shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign diff    = {1'b0, shifted} - {2'b00, div_ff};
   assign borrow  = diff[DATA_WIDTH+1];
   assign last    = busy_ff && (cnt_ff == LAST_STEP);

   // Next-state logic: load on start, then shift one quotient bit in per cycle.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DATA_WIDTH-2:0], ~borrow};
         rem_in = borrow ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control state is reset; the datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = last;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

// ----- sv/divider_64bit_signed_unsigned.sv -----
// Top level of the 64-bit signed/unsigned integer divider.
// A request is taken only in S_IDLE, so the next one waits until the last has left the
// sequencer. The shift-subtract unit retires one quotient bit per cycle; operand and
// result sign fix-up share one negator in S_NEG_A, S_NEG_B, S_NEG_Q and S_NEG_R; S_START
// loads the unit, and S_NEG_R holds until the response register is free.
// A new request is taken while a finished response still waits on rsp_ready.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
module divider_64bit_signed_unsigned #(
   parameter int DATA_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [63:0] req_dividend,
   input  logic [63:0] req_divisor,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_quotient,
   output logic [63:0] rsp_remainder,
   output logic        rsp_div_by_zero
);
   import div64_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_NEG_A,
      S_NEG_B,
      S_START,
      S_DIVIDE,
      S_NEG_Q,
      S_NEG_R
   } state_type;

   state_type             state_ff, state_in;
   logic [DATA_WIDTH-1:0] op_a_ff, op_a_in;
   logic [DATA_WIDTH-1:0] op_b_ff, op_b_in;
   logic                  sign_a_ff, sign_a_in;
   logic                  sign_b_ff, sign_b_in;
   logic                  dbz_ff, dbz_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [63:0]           rsp_quotient_ff, rsp_quotient_in;
   logic [63:0]           rsp_remainder_ff, rsp_remainder_in;
   logic                  rsp_dbz_ff, rsp_dbz_in;

   logic                  req_fire;
   logic                  rsp_free;
   logic                  is_signed;
   logic [DATA_WIDTH-1:0] in_a;
   logic [DATA_WIDTH-1:0] in_b;

   logic                  neg_en;
   logic [DATA_WIDTH-1:0] neg_value;
   logic [DATA_WIDTH-1:0] neg_result;

   div64_status_type      core_status;
   logic [DATA_WIDTH-1:0] core_quotient;
   logic [DATA_WIDTH-1:0] core_remainder;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign is_signed = (req_command == CMD_SIGNED);
   assign in_a      = req_dividend[DATA_WIDTH-1:0];
   assign in_b      = req_divisor[DATA_WIDTH-1:0];

   // The shared negator is steered by the current fix-up step.
   always_comb begin
      neg_en    = 1'b0;
      neg_value = op_a_ff;
      unique case (state_ff)
         S_NEG_A: begin
            neg_en    = sign_a_ff;
            neg_value = op_a_ff;
         end
         S_NEG_B: begin
            neg_en    = sign_b_ff;
            neg_value = op_b_ff;
         end
         S_NEG_Q: begin
            neg_en    = sign_a_ff ^ sign_b_ff;
            neg_value = core_quotient;
         end
         S_NEG_R: begin
            neg_en    = sign_a_ff;
            neg_value = core_remainder;
         end
         default: begin
            neg_en    = 1'b0;
            neg_value = op_a_ff;
         end
      endcase
   end

   div64_cneg #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_cneg (
      .enable(neg_en),
      .value (neg_value),
      .result(neg_result)
   );

   div64_core #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_START),
      .dividend (op_a_ff),
      .divisor  (op_b_ff),
      .status   (core_status),
      .quotient (core_quotient),
      .remainder(core_remainder)
   );

   // Sequencer next state and response register updates.
   always_comb begin
      state_in         = state_ff;
      op_a_in          = op_a_ff;
      op_b_in          = op_b_ff;
      sign_a_in        = sign_a_ff;
      sign_b_in        = sign_b_ff;
      dbz_in           = dbz_ff;
      quo_in           = quo_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_quotient_in  = rsp_quotient_ff;
      rsp_remainder_in = rsp_remainder_ff;
      rsp_dbz_in       = rsp_dbz_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_a_in   = in_a;
               op_b_in   = in_b;
               sign_a_in = is_signed && in_a[DATA_WIDTH-1];
               sign_b_in = is_signed && in_b[DATA_WIDTH-1];
               dbz_in    = (in_b == '0);
               state_in  = S_NEG_A;
            end
         end
         S_NEG_A: begin
            op_a_in  = neg_result;
            state_in = S_NEG_B;
         end
         S_NEG_B: begin
            op_b_in  = neg_result;
            state_in = S_START;
         end
         S_START: begin
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (core_status.done) begin
               state_in = S_NEG_Q;
            end
         end
         S_NEG_Q: begin
            quo_in   = neg_result;
            state_in = S_NEG_R;
         end
         S_NEG_R: begin
            // Hold here until the response register is free.
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_quotient_in  = dbz_ff ? 64'd0 : 64'(quo_ff);
               rsp_remainder_in = dbz_ff ? 64'd0 : 64'(neg_result);
               rsp_dbz_in       = dbz_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_a_ff          <= op_a_in;
      op_b_ff          <= op_b_in;
      sign_a_ff        <= sign_a_in;
      sign_b_ff        <= sign_b_in;
      dbz_ff           <= dbz_in;
      quo_ff           <= quo_in;
      rsp_quotient_ff  <= rsp_quotient_in;
      rsp_remainder_ff <= rsp_remainder_in;
      rsp_dbz_ff       <= rsp_dbz_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_quotient    = rsp_quotient_ff;
   assign rsp_remainder   = rsp_remainder_ff;
   assign rsp_div_by_zero = rsp_dbz_ff;

   // The divider unit never runs while a new request can be taken.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && core_status.busy))
      else $error("divider unit busy while request port is ready");

   // An accepted request always enters the operand fix-up step.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_NEG_A))
      else $error("accepted request did not start operand fix-up");

   // A divide-by-zero response carries zero results.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_by_zero) |-> (rsp_quotient == 64'd0 && rsp_remainder == 64'd0))
      else $error("divide-by-zero response with nonzero results");

   // Response bits above the data width are always zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_quotient >> DATA_WIDTH) == 64'd0
                     && (rsp_remainder >> DATA_WIDTH) == 64'd0))
      else $error("response bits set above the data width");

   // The unit reports completion only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      core_status.done |-> (state_ff == S_DIVIDE))
      else $error("divider completion outside the divide step");

endmodule

// ----- verif/div_result_checker.sv -----
// Checker that predicts and compares every divider response against its request.
`timescale 1ns / 1ps

module div_result_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             req_command,
   input  logic [div64_pkg::PORT_WIDTH-1:0] req_dividend,
   input  logic [div64_pkg::PORT_WIDTH-1:0] req_divisor,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [div64_pkg::PORT_WIDTH-1:0] rsp_quotient,
   input  logic [div64_pkg::PORT_WIDTH-1:0] rsp_remainder,
   input  logic                             rsp_div_by_zero,
   output int                               mismatch_count,
   output int                               quotients_owed
);
   import div64_pkg::*;

   typedef struct packed {
      logic [PORT_WIDTH-1:0] quotient;
      logic [PORT_WIDTH-1:0] remainder;
      logic                  div_by_zero;
   } division_result_type;

   division_result_type pending_quotients[$];

   // Quotient and remainder of one request. Signed mode divides the magnitudes, then the
   // quotient is negated when the signs differ and the remainder follows the dividend.
   function automatic division_result_type predict_division(input logic mode,
                                                            input logic [PORT_WIDTH-1:0] num,
                                                            input logic [PORT_WIDTH-1:0] den);
      division_result_type   res;
      logic                  num_neg;
      logic                  den_neg;
      logic [PORT_WIDTH-1:0] mag_num;
      logic [PORT_WIDTH-1:0] mag_den;
      logic [PORT_WIDTH-1:0] quo;
      logic [PORT_WIDTH-1:0] rem;
      num_neg = (mode == CMD_SIGNED) && num[PORT_WIDTH-1];
      den_neg = (mode == CMD_SIGNED) && den[PORT_WIDTH-1];
      mag_num = num_neg ? (~num + 1'b1) : num;
      mag_den = den_neg ? (~den + 1'b1) : den;
      if (den == '0) begin
         res.quotient    = '0;
         res.remainder   = '0;
         res.div_by_zero = 1'b1;
      end else begin
         quo = mag_num / mag_den;
         rem = mag_num % mag_den;
         if (num_neg != den_neg) begin
            quo = ~quo + 1'b1;
         end
         if (num_neg) begin
            rem = ~rem + 1'b1;
         end
         res.quotient    = quo;
         res.remainder   = rem;
         res.div_by_zero = 1'b0;
      end
      return res;
   endfunction

   initial begin
      mismatch_count = 0;
      quotients_owed = 0;
   end

   // Record each accepted request and check each accepted response in order.
   always @(posedge clock) begin
      division_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_quotients.push_back(predict_division(req_command, req_dividend,
                                                         req_divisor));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_quotients.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("ERROR: response with no request outstanding: q=%h r=%h dbz=%b",
                           rsp_quotient, rsp_remainder, rsp_div_by_zero);
               end
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = pending_quotients.pop_front();
               if (rsp_quotient !== want.quotient || rsp_remainder !== want.remainder ||
                   rsp_div_by_zero !== want.div_by_zero) begin
                  if (mismatch_count < 10) begin
                     $display("ERROR: quotient exp %h got %h", want.quotient, rsp_quotient);
                     $display("       remainder exp %h got %h", want.remainder,
                              rsp_remainder);
                     $display("       div_by_zero exp %b got %b", want.div_by_zero,
                              rsp_div_by_zero);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         quotients_owed <= pending_quotients.size();
      end
   end

endmodule

// ----- verif/tb.sv -----
// Testbench top: drives division requests and response back-pressure, and gives the verdict.
`timescale 1ns / 1ps

module tb;
   import div64_pkg::*;

   localparam logic [PORT_WIDTH-1:0] MOST_NEG  = {1'b1, {(PORT_WIDTH-1){1'b0}}};
   localparam logic [PORT_WIDTH-1:0] MOST_POS  = {1'b0, {(PORT_WIDTH-1){1'b1}}};
   localparam logic [PORT_WIDTH-1:0] ALL_ONES  = {PORT_WIDTH{1'b1}};
   localparam int                    RAND_REQS = 1600;
   localparam int                    CALM_TAIL = 160;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_command;
   logic [PORT_WIDTH-1:0] req_dividend;
   logic [PORT_WIDTH-1:0] req_divisor;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [PORT_WIDTH-1:0] rsp_quotient;
   logic [PORT_WIDTH-1:0] rsp_remainder;
   logic                  rsp_div_by_zero;
   int                    mismatch_count;
   int                    quotients_owed;
   bit                    sender_gaps;
   bit                    receiver_stalls;

   divider_64bit_signed_unsigned u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_dividend    (req_dividend),
      .req_divisor     (req_divisor),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_quotient    (rsp_quotient),
      .rsp_remainder   (rsp_remainder),
      .rsp_div_by_zero (rsp_div_by_zero)
   );

   div_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_dividend    (req_dividend),
      .req_divisor     (req_divisor),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_quotient    (rsp_quotient),
      .rsp_remainder   (rsp_remainder),
      .rsp_div_by_zero (rsp_div_by_zero),
      .mismatch_count  (mismatch_count),
      .quotients_owed  (quotients_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run, several times the slowest legal completion.
   initial begin
      #6_000_000;
      $display("FAIL divider_64bit_signed_unsigned");
      $finish;
   end

   // Response back-pressure: random bursts of low ready while stalls are enabled.
   always @(posedge clock) begin
      if (!reset && receiver_stalls && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      rsp_ready <= 1'b1;
   end

   // Present one request and hold it until the divider takes it.
   task automatic issue_division(input logic mode, input logic [PORT_WIDTH-1:0] num,
                                 input logic [PORT_WIDTH-1:0] den);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= mode;
      req_dividend <= num;
      req_divisor  <= den;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Operand drawn from a mix of corner values, small numbers and varied magnitudes.
   function automatic logic [PORT_WIDTH-1:0] pick_operand();
      logic [PORT_WIDTH-1:0] val;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: val = '0;
               1: val = 1;
               2: val = ALL_ONES;
               3: val = MOST_NEG;
               default: val = MOST_POS;
            endcase
         end
         1, 2: val = PORT_WIDTH'($urandom_range(0, 15));
         3, 4, 5: val = {$urandom, $urandom};
         default: begin
            val = {$urandom, $urandom} >> $urandom_range(0, PORT_WIDTH - 1);
            if ($urandom_range(0, 1) == 1) begin
               val = ~val + 1'b1;
            end
         end
      endcase
      return val;
   endfunction

   // Reset, directed corner cases, random traffic, then drain and verdict.
   initial begin
      logic [PORT_WIDTH-1:0] num;
      logic [PORT_WIDTH-1:0] den;
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_command  <= CMD_UNSIGNED;
      req_dividend <= '0;
      req_divisor  <= '0;
      rsp_ready    <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Field extremes, zero divisors and the signed overflow case.
      issue_division(CMD_UNSIGNED, '0, '0);
      issue_division(CMD_UNSIGNED, ALL_ONES, '0);
      issue_division(CMD_SIGNED, MOST_NEG, '0);
      issue_division(CMD_UNSIGNED, ALL_ONES, 1);
      issue_division(CMD_UNSIGNED, ALL_ONES, ALL_ONES);
      issue_division(CMD_UNSIGNED, '0, ALL_ONES);
      issue_division(CMD_UNSIGNED, MOST_NEG, 3);
      issue_division(CMD_UNSIGNED, 100, 7);
      issue_division(CMD_UNSIGNED, 5, MOST_NEG);
      issue_division(CMD_SIGNED, MOST_NEG, ALL_ONES);
      issue_division(CMD_SIGNED, MOST_NEG, 1);
      issue_division(CMD_SIGNED, ALL_ONES, MOST_NEG);
      issue_division(CMD_SIGNED, MOST_NEG, MOST_NEG);
      issue_division(CMD_SIGNED, MOST_POS, ALL_ONES);
      issue_division(CMD_SIGNED, MOST_POS, MOST_NEG);
      issue_division(CMD_SIGNED, -64'sd7, 2);
      issue_division(CMD_SIGNED, 7, -64'sd2);
      issue_division(CMD_SIGNED, -64'sd7, -64'sd2);
      issue_division(CMD_SIGNED, 7, 2);
      issue_division(CMD_SIGNED, '0, ALL_ONES);
      issue_division(CMD_SIGNED, 5, '0);

      // Random traffic in blocks, each block with its own idling pattern.
      for (int i = 0; i < RAND_REQS; i++) begin
         if (i % 100 == 0) begin
            sender_gaps     = (i < RAND_REQS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            receiver_stalls = (i < RAND_REQS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
         end
         if (i >= RAND_REQS - CALM_TAIL) begin
            sender_gaps     = 1'b0;
            receiver_stalls = 1'b0;
         end
         num = pick_operand();
         den = ($urandom_range(0, 31) == 0) ? '0 : pick_operand();
         issue_division($urandom_range(0, 1) ? CMD_SIGNED : CMD_UNSIGNED, num, den);
      end
      req_valid <= 1'b0;

      // Wait for every owed response, then allow for one more full division.
      @(posedge clock);
      while (quotients_owed != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && quotients_owed == 0) begin
         $display("PASS divider_64bit_signed_unsigned");
      end else begin
         $display("FAIL divider_64bit_signed_unsigned");
      end
      $finish;
   end

endmodule
